@@ rtl/core/ctb_pkg.sv @@
// Shared types and constants for the countdown timer bank.
`default_nettype none

package ctb_pkg;

    localparam int unsigned KIND_W    = 2;
    localparam int unsigned INDEX_W   = 3;
    localparam int unsigned COUNT_W   = 15;
    localparam int unsigned MS_W      = 32;
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 56;

    localparam logic [MS_W-1:0] MS_PER_TICK = 32'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_SET   = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_CHECK = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_EXEC = 2'd1,
        ST_OUT  = 2'd2
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
    } ctb_cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/countdown_timer_bank.sv @@
// Top level of the countdown timer bank: stream ports, controller and datapath.
//
//  channel | dir | tdata (low bit first)                      | tuser
//  s_      | in  | timer_index[2:0], count_value[17:3], pad    | kind[1:0]
//  m_      | out | expired_found[0], expired_index[3:1],       | -
//          |     | read_count[18:4], read_enabled[19],        |
//          |     | elapsed_ms[51:20], pad                     |
//
//  Each item is captured, executed and presented in turn; the state
//  machine handles one item at a time, so the next item is taken in the
//  cycle after its result leaves. A stall on m_tready holds the result and
//  keeps s_tready low. Reset clears all timers, enables and elapsed time
//  directly, with no clearing pass.
`default_nettype none

module countdown_timer_bank #(
    parameter int unsigned NUM_TIMERS = 8
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [ctb_pkg::S_TDATA_W-1:0]     s_tdata,  // timer_index, count_value
    input  wire logic [ctb_pkg::KIND_W-1:0]        s_tuser,  // kind
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // expired_found, expired_index, read_count, read_enabled, elapsed_ms
    output logic [ctb_pkg::M_TDATA_W-1:0]          m_tdata
);

    ctb_pkg::ctb_cmd_t                 cmd;
    logic                              res_found;
    logic [ctb_pkg::INDEX_W-1:0]       res_index;
    logic [ctb_pkg::COUNT_W-1:0]       res_count;
    logic                              res_enabled;
    logic [ctb_pkg::MS_W-1:0]          res_elapsed;

    ctb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    ctb_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .in_kind     (s_tuser),
        .in_index    (s_tdata[2:0]),
        .in_count    (s_tdata[17:3]),
        .res_found   (res_found),
        .res_index   (res_index),
        .res_count   (res_count),
        .res_enabled (res_enabled),
        .res_elapsed (res_elapsed)
    );

    assign m_tdata = {4'b0000, res_elapsed, res_enabled, res_count, res_index, res_found};

endmodule

`default_nettype wire

@@ rtl/core/ctb_ctrl.sv @@
// Controller state machine for the countdown timer bank.
`default_nettype none

module ctb_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output ctb_pkg::ctb_cmd_t      cmd
);

    ctb_pkg::state_t state_reg;
    ctb_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ctb_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ctb_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ctb_pkg::ST_EXEC;
                end
            end
            ctb_pkg::ST_EXEC: begin
                state_next = ctb_pkg::ST_OUT;
            end
            ctb_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = ctb_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ctb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        m_tvalid = 1'b0;
        cmd      = '0;
        case (state_reg)
            ctb_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ctb_pkg::ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ctb_pkg::ST_OUT: begin
                m_tvalid = 1'b1;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and output sides open at once");

    a_load_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> cmd.exec)
        else $error("accepted item not executed next cycle");

    a_exec_then_out: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec |=> m_tvalid)
        else $error("executed item not presented");

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && !s_tready))
        else $error("stalled result dropped");

endmodule

`default_nettype wire

@@ rtl/core/ctb_datapath.sv @@
// Timer state, item register and result register for the countdown timer bank.
`default_nettype none

module ctb_datapath #(
    parameter int unsigned NUM_TIMERS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ctb_pkg::ctb_cmd_t                   cmd,
    input  wire logic [ctb_pkg::KIND_W-1:0]          in_kind,
    input  wire logic [ctb_pkg::INDEX_W-1:0]         in_index,
    input  wire logic [ctb_pkg::COUNT_W-1:0]         in_count,
    output logic                                     res_found,
    output logic [ctb_pkg::INDEX_W-1:0]              res_index,
    output logic [ctb_pkg::COUNT_W-1:0]              res_count,
    output logic                                     res_enabled,
    output logic [ctb_pkg::MS_W-1:0]                 res_elapsed
);

    localparam int unsigned POS_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    ctb_pkg::kind_t                    kind_reg;
    logic [ctb_pkg::INDEX_W-1:0]       index_reg;
    logic [ctb_pkg::COUNT_W-1:0]       value_reg;

    logic [NUM_TIMERS-1:0]             en_reg;
    logic [NUM_TIMERS-1:0]             en_next;
    logic [ctb_pkg::COUNT_W-1:0]       count_reg  [NUM_TIMERS];
    logic [ctb_pkg::COUNT_W-1:0]       count_next [NUM_TIMERS];
    logic [ctb_pkg::MS_W-1:0]          elapsed_reg;
    logic [ctb_pkg::MS_W-1:0]          elapsed_next;

    logic [NUM_TIMERS-1:0]             hit;
    logic                              scan_found;
    logic [POS_W-1:0]                  scan_pos;
    logic [ctb_pkg::INDEX_W-1:0]       scan_index;
    logic                              rd_enabled;
    logic [ctb_pkg::COUNT_W-1:0]       rd_count;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg  <= ctb_pkg::kind_t'(in_kind);
            index_reg <= in_index;
            value_reg <= in_count;
        end
    end

    // Decode the addressed timer; indexes beyond the bank match nothing.
    always_comb begin
        for (int i = 0; i < NUM_TIMERS; i++) begin
            hit[i] = (32'(index_reg) == 32'(i));
        end
    end

    // Lowest enabled timer whose count has run out.
    always_comb begin
        scan_found = 1'b0;
        scan_pos   = '0;
        scan_index = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (!scan_found && en_reg[i] && (count_reg[i] == '0)) begin
                scan_found = 1'b1;
                scan_pos   = POS_W'(i);
                scan_index = ctb_pkg::INDEX_W'(i);
            end
        end
    end

    always_comb begin
        rd_enabled = 1'b0;
        rd_count   = '0;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            if (hit[i] && en_reg[i]) begin
                rd_enabled = 1'b1;
                rd_count   = count_reg[i];
            end
        end
    end

    always_comb begin
        elapsed_next = elapsed_reg;
        for (int i = 0; i < NUM_TIMERS; i++) begin
            en_next[i]    = en_reg[i];
            count_next[i] = count_reg[i];
            if (cmd.exec) begin
                case (kind_reg)
                    ctb_pkg::KIND_SET: begin
                        if (hit[i]) begin
                            if (value_reg != '0) begin
                                en_next[i]    = 1'b1;
                                count_next[i] = value_reg;
                            end else begin
                                en_next[i] = 1'b0;
                            end
                        end
                    end
                    ctb_pkg::KIND_TICK: begin
                        if (count_reg[i] != '0) begin
                            count_next[i] = count_reg[i] - 1'b1;
                        end
                    end
                    ctb_pkg::KIND_CHECK: begin
                        if (scan_found && (scan_pos == POS_W'(i))) begin
                            en_next[i] = 1'b0;
                        end
                    end
                    default: begin
                        en_next[i] = en_reg[i];
                    end
                endcase
            end
        end
        if (cmd.exec && (kind_reg == ctb_pkg::KIND_TICK)) begin
            elapsed_next = elapsed_reg + ctb_pkg::MS_PER_TICK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            en_reg      <= '0;
            elapsed_reg <= '0;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= '0;
            end
        end else begin
            en_reg      <= en_next;
            elapsed_reg <= elapsed_next;
            for (int i = 0; i < NUM_TIMERS; i++) begin
                count_reg[i] <= count_next[i];
            end
        end
    end

    // Capture the result; it reports the elapsed time after this item's update.
    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            res_found   <= (kind_reg == ctb_pkg::KIND_CHECK) && scan_found;
            res_index   <= (kind_reg == ctb_pkg::KIND_CHECK) ? scan_index : '0;
            res_enabled <= (kind_reg == ctb_pkg::KIND_READ) && rd_enabled;
            res_count   <= (kind_reg == ctb_pkg::KIND_READ) ? rd_count : '0;
            res_elapsed <= elapsed_next;
        end
    end

    a_tick_adds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (kind_reg == ctb_pkg::KIND_TICK))
        |=> (elapsed_reg == $past(elapsed_reg) + ctb_pkg::MS_PER_TICK))
        else $error("tick did not advance elapsed time");

    a_check_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.exec && (kind_reg == ctb_pkg::KIND_CHECK) && scan_found)
        |=> (!en_reg[$past(scan_pos)] && res_found))
        else $error("expired timer not disabled");

    a_idle_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        !cmd.exec |=> (en_reg == $past(en_reg) && elapsed_reg == $past(elapsed_reg)))
        else $error("timer state changed without an item");

endmodule

`default_nettype wire
